@@ rtl/sds_pkg.sv @@
// Shared types, constants and a helper function of the SCAN disk scheduler.
package sds_pkg;

    localparam int MAX_BATCH_DEF = 32;
    localparam int CYL_W         = 16;
    localparam int SEEK_W        = CYL_W + 1;
    localparam int DC_W          = 17;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;

    localparam logic [DC_W-1:0] DISK_CYL_RST = 17'h10000;

    typedef enum logic [1:0] {
        REG_DISK_CYL   = 2'd0,
        REG_HEAD_START = 2'd1,
        REG_SWEEP_UP   = 2'd2
    } sds_reg_idx_t;

    typedef struct packed {
        logic [CYL_W-1:0] edge_cyl;
        logic [CYL_W-1:0] head_start;
        logic             sweep_up;
    } sds_cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SEG_RD,
        S_SEG_OUT,
        S_EDGE
    } sds_state_t;

    function automatic logic [CYL_W-1:0] edge_of(input logic [DC_W-1:0] dc);
        logic [DC_W-1:0] last_cyl;
        begin
            last_cyl = (dc == '0) ? '0 : dc - 1'b1;
            if (last_cyl > DC_W'({CYL_W{1'b1}}))
                edge_of = {CYL_W{1'b1}};
            else
                edge_of = last_cyl[CYL_W-1:0];
        end
    endfunction

endpackage

@@ rtl/sds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sds_cfg.sv @@
// APB configuration registers of the SCAN disk scheduler.
module sds_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sds_pkg::APB_AW-1:0]   paddr,
    input  logic [sds_pkg::APB_DW-1:0]   pwdata,
    output logic [sds_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output sds_pkg::sds_cfg_t            cfg
);
    import sds_pkg::*;

    logic [DC_W-1:0]  disk_cyl_reg;
    logic [CYL_W-1:0] head_start_reg;
    logic             sweep_up_reg;
    logic             wr_en;
    sds_reg_idx_t     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = sds_reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_cyl_reg   <= DISK_CYL_RST;
            head_start_reg <= '0;
            sweep_up_reg   <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DISK_CYL:   disk_cyl_reg   <= pwdata[DC_W-1:0];
                REG_HEAD_START: head_start_reg <= pwdata[CYL_W-1:0];
                REG_SWEEP_UP:   sweep_up_reg   <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DISK_CYL:   prdata = APB_DW'(disk_cyl_reg);
            REG_HEAD_START: prdata = APB_DW'(head_start_reg);
            REG_SWEEP_UP:   prdata = APB_DW'(sweep_up_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.edge_cyl   = edge_of(disk_cyl_reg);
    assign cfg.head_start = head_start_reg;
    assign cfg.sweep_up   = sweep_up_reg;

endmodule

@@ rtl/sds_ctrl.sv @@
// Sequencer for sorted insertion, split search and SCAN stop generation.
module sds_ctrl #(
    parameter int MAX_BATCH = sds_pkg::MAX_BATCH_DEF,
    parameter int IDX_W     = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sds_pkg::sds_cfg_t            cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sds_pkg::CYL_W-1:0]    request_cylinder,
    input  logic                         batch_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sds_pkg::CYL_W-1:0]    stop_cylinder,
    output logic                         edge_stop,
    output logic [sds_pkg::CYL_W-1:0]    move_distance,
    output logic [sds_pkg::SEEK_W-1:0]   seek_total,
    output logic                         final_stop,
    output logic                         mem_we,
    output logic [IDX_W-1:0]             mem_waddr,
    output logic [sds_pkg::CYL_W-1:0]    mem_wdata,
    output logic [IDX_W-1:0]             mem_raddr,
    input  logic [sds_pkg::CYL_W-1:0]    mem_rdata
);
    import sds_pkg::*;

    localparam int CNT_W = $clog2(MAX_BATCH + 1);

    sds_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [CYL_W-1:0]  cyl_reg, cyl_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  split_reg, split_next;
    logic [IDX_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              ret_reg, ret_next;
    logic              up_reg, up_next;
    logic [CYL_W-1:0]  head_reg, head_next;
    logic [SEEK_W-1:0] seek_reg, seek_next;

    logic              out_valid_reg, out_valid_next;
    logic [CYL_W-1:0]  stop_reg, stop_next;
    logic              edge_reg, edge_next;
    logic [CYL_W-1:0]  move_reg;
    logic [SEEK_W-1:0] seek_out_reg;
    logic              final_reg, final_next;

    logic              out_load;
    logic              out_free;
    logic [CYL_W-1:0]  move_val;
    logic [SEEK_W:0]   seek_sum;
    logic [SEEK_W-1:0] seek_sat;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  split_m1;
    logic [CNT_W-1:0]  upper_size;

    assign out_free   = !out_valid_reg || out_ready;
    assign count_m1   = count_reg - 1'b1;
    assign split_m1   = split_reg - 1'b1;
    assign upper_size = count_reg - split_reg;

    assign move_val = (stop_next >= head_reg) ? stop_next - head_reg : head_reg - stop_next;
    assign seek_sum = {1'b0, seek_reg} + (SEEK_W + 1)'(move_val);
    assign seek_sat = seek_sum[SEEK_W] ? {SEEK_W{1'b1}} : seek_sum[SEEK_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            seek_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            seek_reg      <= seek_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        cyl_reg    <= cyl_next;
        last_reg   <= last_next;
        split_reg  <= split_next;
        cursor_reg <= cursor_next;
        remain_reg <= remain_next;
        ret_reg    <= ret_next;
        up_reg     <= up_next;
        if (out_load)
        begin
            stop_reg     <= stop_next;
            edge_reg     <= edge_next;
            move_reg     <= move_val;
            seek_out_reg <= seek_sat;
            final_reg    <= final_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        cyl_next    = cyl_reg;
        last_next   = last_reg;
        split_next  = split_reg;
        cursor_next = cursor_reg;
        remain_next = remain_reg;
        ret_next    = ret_reg;
        up_next     = up_reg;
        head_next   = head_reg;
        seek_next   = seek_reg;
        stop_next   = mem_rdata;
        edge_next   = 1'b0;
        final_next  = 1'b0;
        out_load    = 1'b0;
        in_ready    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = cyl_reg;
        mem_raddr   = cursor_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cyl_next   = request_cylinder;
                    last_next  = batch_end;
                    split_next = '0;
                    if (count_reg < CNT_W'(MAX_BATCH))
                    begin
                        pos_next = count_reg[IDX_W-1:0];
                        if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = request_cylinder;
                            count_next = CNT_W'(1);
                            state_next = batch_end ? S_SRCH_RD : S_IDLE;
                        end
                        else
                        begin
                            mem_raddr  = count_m1[IDX_W-1:0];
                            state_next = S_INSERT;
                        end
                    end
                    else
                    begin
                        state_next = batch_end ? S_SRCH_RD : S_IDLE;
                    end
                end
            end

            S_INSERT:
            begin
                mem_we = 1'b1;
                if (pos_reg == '0 || !(mem_rdata > cyl_reg))
                begin
                    mem_wdata  = cyl_reg;
                    count_next = CNT_W'(count_reg + 1'b1);
                    state_next = last_reg ? S_SRCH_RD : S_IDLE;
                end
                else
                begin
                    mem_wdata = mem_rdata;
                    pos_next  = IDX_W'(pos_reg - 1'b1);
                    mem_raddr = IDX_W'(pos_reg - 2'd2);
                end
            end

            S_SRCH_RD:
            begin
                mem_raddr = split_reg[IDX_W-1:0];
                if (split_reg == count_reg)
                begin
                    state_next = S_SEG_RD;
                end
                else
                begin
                    state_next = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP:
            begin
                mem_raddr = split_reg[IDX_W-1:0];
                if (mem_rdata < cfg.head_start)
                begin
                    split_next = CNT_W'(split_reg + 1'b1);
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    state_next = S_SEG_RD;
                end
            end

            S_SEG_RD:
            begin
                if (remain_reg == '0)
                begin
                    if (!ret_reg)
                    begin
                        state_next = S_EDGE;
                    end
                    else
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_SEG_OUT;
                end
            end

            S_SEG_OUT:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    final_next  = ret_reg && (remain_reg == CNT_W'(1));
                    cursor_next = up_reg ? IDX_W'(cursor_reg + 1'b1)
                                         : IDX_W'(cursor_reg - 1'b1);
                    remain_next = remain_reg - 1'b1;
                    head_next   = stop_next;
                    seek_next   = seek_sat;
                    state_next  = S_SEG_RD;
                end
            end

            S_EDGE:
            begin
                stop_next = cfg.sweep_up ? cfg.edge_cyl : '0;
                edge_next = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    final_next = cfg.sweep_up ? (split_reg == '0) : (upper_size == '0);
                    head_next  = stop_next;
                    seek_next  = seek_sat;
                    ret_next   = 1'b1;
                    up_next    = !cfg.sweep_up;
                    if (cfg.sweep_up)
                    begin
                        cursor_next = split_m1[IDX_W-1:0];
                        remain_next = split_reg;
                    end
                    else
                    begin
                        cursor_next = split_reg[IDX_W-1:0];
                        remain_next = upper_size;
                    end
                    state_next = S_SEG_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // set up the first sweep once the split point is known
        if ((state_reg == S_SRCH_RD && split_reg == count_reg) ||
            (state_reg == S_SRCH_CMP && !(mem_rdata < cfg.head_start)))
        begin
            head_next = cfg.head_start;
            seek_next = '0;
            ret_next  = 1'b0;
            up_next   = cfg.sweep_up;
            if (cfg.sweep_up)
            begin
                cursor_next = split_reg[IDX_W-1:0];
                remain_next = upper_size;
            end
            else
            begin
                cursor_next = split_m1[IDX_W-1:0];
                remain_next = split_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid     = out_valid_reg;
    assign stop_cylinder = stop_reg;
    assign edge_stop     = edge_reg;
    assign move_distance = move_reg;
    assign seek_total    = seek_out_reg;
    assign final_stop    = final_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BATCH))
        else $error("request count beyond store depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending transfer");

    a_seg_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEG_OUT |-> remain_reg != '0)
        else $error("stop issued from an empty sweep");

    a_insert_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INSERT |-> CNT_W'(pos_reg) <= count_reg)
        else $error("insert position beyond fill level");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && final_next) |=> ##1 state_reg == S_IDLE)
        else $error("schedule did not end after the last stop");
`endif

endmodule

@@ rtl/scan_disk_scheduler.sv @@
// SCAN disk scheduler: a batch of cylinder requests is inserted in ascending order into a
// one-port-read request memory; the request marked batch_end starts the schedule, which emits
// one transfer per stop (requests on the sweep side, the disk edge, then the rest in reverse).
// Loading a request shifts each stored entry greater than it up one place, as insertion walks
// the memory one entry per cycle (the first request of a batch is written directly). Scheduling
// then searches for the split point, the count of requests below head_start, and emits the
// stops, the edge stop included, paced by the memory's single read port and held while a
// result is not yet taken. A finished result waits in an output register while the next
// batch loads.
module scan_disk_scheduler #(
    parameter int MAX_BATCH = sds_pkg::MAX_BATCH_DEF,
    parameter int IDX_W     = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sds_pkg::APB_AW-1:0]   paddr,
    input  logic [sds_pkg::APB_DW-1:0]   pwdata,
    output logic [sds_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sds_pkg::CYL_W-1:0]    request_cylinder,
    input  logic                         batch_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sds_pkg::CYL_W-1:0]    stop_cylinder,
    output logic                         edge_stop,
    output logic [sds_pkg::CYL_W-1:0]    move_distance,
    output logic [sds_pkg::SEEK_W-1:0]   seek_total,
    output logic                         final_stop
);
    import sds_pkg::*;

    sds_cfg_t         cfg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [CYL_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [CYL_W-1:0] mem_rdata;

    sds_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sds_ram #(
        .WIDTH (CYL_W),
        .DEPTH (MAX_BATCH),
        .AW    (IDX_W)
    ) u_req_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sds_ctrl #(
        .MAX_BATCH (MAX_BATCH),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .request_cylinder (request_cylinder),
        .batch_end        (batch_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .stop_cylinder    (stop_cylinder),
        .edge_stop        (edge_stop),
        .move_distance    (move_distance),
        .seek_total       (seek_total),
        .final_stop       (final_stop),
        .mem_we           (mem_we),
        .mem_waddr        (mem_waddr),
        .mem_wdata        (mem_wdata),
        .mem_raddr        (mem_raddr),
        .mem_rdata        (mem_rdata)
    );

endmodule
